>>> sv/rational_arithmetic_unit_defines.svh
// assertion macros shared by the rational arithmetic unit rtl
// expects clk and rst to be visible in the module that uses them
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RAU_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RAU_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> sv/rau_pkg.sv
// shared types, command codes and controller/datapath interface structs
// for the rational arithmetic unit; no dependencies
`default_nettype none

package rau_pkg;

  localparam int OPW       = 16;
  localparam int PRODW     = 2 * OPW;
  localparam int NUM_W     = 32;
  localparam int DEN_W     = 31;
  localparam int CODE_W    = 4;
  localparam int SH_W      = $clog2(OPW);
  localparam int DIV_CNT_W = $clog2(OPW + 1);

  typedef logic signed [OPW-1:0]   opd_t;
  typedef logic        [OPW-1:0]   mag_t;
  typedef logic signed [PRODW-1:0] prod_t;
  typedef logic signed [NUM_W-1:0] num_t;
  typedef logic signed [DEN_W-1:0] den_t;
  typedef logic        [CODE_W-1:0] code_t;
  typedef logic        [SH_W-1:0]  sh_t;
  typedef logic        [DIV_CNT_W-1:0] dcnt_t;

  localparam code_t CMD_ADD  = 4'd0;
  localparam code_t CMD_SUB  = 4'd1;
  localparam code_t CMD_MUL  = 4'd2;
  localparam code_t CMD_DIV  = 4'd3;
  localparam code_t CMD_GT   = 4'd4;
  localparam code_t CMD_LT   = 4'd5;
  localparam code_t CMD_EQ   = 4'd6;
  localparam code_t CMD_NE   = 4'd7;
  localparam code_t CMD_RED  = 4'd8;
  localparam code_t CMD_SWAP = 4'd9;

  // which cross product the shared multiplier forms this cycle
  typedef enum logic [1:0] {
    MS_NONE,
    MS_P1,
    MS_P2,
    MS_PD
  } mul_step_t;

  typedef struct packed {
    logic      capture;
    mul_step_t mul_step;
    logic      gcd_init;
    logic      gcd_step;
    logic      div_start;
    logic      div_den;
    logic      qn_load;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    code_t op;
    logic  a_num_zero;
    logic  a_den_zero;
    logic  gcd_done;
    logic  div_busy;
    logic  div_done;
  } dp_stat_t;

  function automatic mag_t mag_of(opd_t v);
    mag_t m;
    m = v[OPW-1] ? mag_t'(-v) : mag_t'(v);
    return m;
  endfunction

endpackage

`default_nettype wire

>>> sv/rau_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on rau_pkg
`default_nettype none

module rau_div (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire rau_pkg::mag_t dividend,
  input  wire rau_pkg::mag_t divisor,
  output rau_pkg::mag_t      quotient,
  output logic               busy,
  output logic               done
);

  rau_pkg::mag_t  rem;
  rau_pkg::mag_t  quo;
  rau_pkg::mag_t  dsr;
  rau_pkg::dcnt_t cnt;
  logic [rau_pkg::OPW:0] shifted;
  logic [rau_pkg::OPW:0] diff;
  logic                  fits;

  assign shifted  = {rem, quo[rau_pkg::OPW-1]};
  assign diff     = shifted - {1'b0, dsr};
  assign fits     = shifted >= {1'b0, dsr};
  assign busy     = cnt != '0;
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == rau_pkg::dcnt_t'(1));
      if (start) begin
        cnt <= rau_pkg::dcnt_t'(rau_pkg::OPW);
      end else if (busy) begin
        cnt <= cnt - rau_pkg::dcnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      // remainder stays below the divisor, so it fits the operand width
      rem <= fits ? diff[rau_pkg::OPW-1:0] : shifted[rau_pkg::OPW-1:0];
      quo <= {quo[rau_pkg::OPW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

>>> sv/rau_dpath.sv
// datapath: operand registers, shared multiplier, binary gcd, divider
// and the result register; depends on rau_pkg and rau_div
`default_nettype none

module rau_dpath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rau_pkg::dp_cmd_t  cmd,
  output rau_pkg::dp_stat_t      stat,
  input  wire rau_pkg::code_t    op_in,
  input  wire rau_pkg::opd_t     a_num,
  input  wire rau_pkg::opd_t     a_den,
  input  wire rau_pkg::opd_t     b_num,
  input  wire rau_pkg::opd_t     b_den,
  output rau_pkg::num_t          res_num,
  output rau_pkg::den_t          res_den,
  output logic                   cmp_true,
  output logic                   zero_den
);

  rau_pkg::code_t op_q;
  rau_pkg::opd_t  an_q, ad_q, bn_q, bd_q;
  rau_pkg::prod_t p1, p2, pd;
  rau_pkg::opd_t  mul_a, mul_b;
  rau_pkg::prod_t prod;
  rau_pkg::mag_t  mag_an, mag_ad;
  rau_pkg::mag_t  gx, gy, gdiff_xy, gdiff_yx, g;
  rau_pkg::sh_t   gk;
  rau_pkg::mag_t  qn, q_div;
  rau_pkg::mag_t  div_dividend;
  logic           div_busy, div_done;
  logic           an_zero, ad_zero, bn_zero, bd_zero;
  rau_pkg::prod_t sum, diff;
  rau_pkg::num_t  r_num;
  rau_pkg::den_t  r_den;
  logic           r_ct, r_zd;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= op_in;
      an_q <= a_num;
      ad_q <= a_den;
      bn_q <= b_num;
      bd_q <= b_den;
    end
  end

  assign an_zero = an_q == '0;
  assign ad_zero = ad_q == '0;
  assign bn_zero = bn_q == '0;
  assign bd_zero = bd_q == '0;
  assign mag_an  = rau_pkg::mag_of(an_q);
  assign mag_ad  = rau_pkg::mag_of(ad_q);

  // operand steering for the single multiplier
  always_comb begin
    mul_a = an_q;
    mul_b = bd_q;
    unique case (cmd.mul_step)
      rau_pkg::MS_P1: begin
        mul_a = an_q;
        mul_b = (op_q == rau_pkg::CMD_MUL) ? bn_q : bd_q;
      end
      rau_pkg::MS_P2: begin
        mul_a = bn_q;
        mul_b = ad_q;
      end
      rau_pkg::MS_PD: begin
        mul_a = ad_q;
        mul_b = (op_q == rau_pkg::CMD_DIV) ? bn_q : bd_q;
      end
      rau_pkg::MS_NONE: begin
        mul_a = an_q;
        mul_b = bd_q;
      end
      default: begin
        mul_a = an_q;
        mul_b = bd_q;
      end
    endcase
  end

  assign prod = rau_pkg::prod_t'(mul_a) * rau_pkg::prod_t'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.mul_step == rau_pkg::MS_P1) p1 <= prod;
    if (cmd.mul_step == rau_pkg::MS_P2) p2 <= prod;
    if (cmd.mul_step == rau_pkg::MS_PD) pd <= prod;
  end

  // binary gcd of the magnitudes; both start nonzero
  assign gdiff_xy = gx - gy;
  assign gdiff_yx = gy - gx;
  assign g        = rau_pkg::mag_t'(gx << gk);

  always_ff @(posedge clk) begin
    if (cmd.gcd_init) begin
      gx <= mag_an;
      gy <= mag_ad;
      gk <= '0;
    end else if (cmd.gcd_step) begin
      priority if (!gx[0] && !gy[0]) begin
        gx <= gx >> 1;
        gy <= gy >> 1;
        gk <= gk + rau_pkg::sh_t'(1);
      end else if (!gx[0]) begin
        gx <= gx >> 1;
      end else if (!gy[0]) begin
        gy <= gy >> 1;
      end else if (gx > gy) begin
        gx <= gdiff_xy >> 1;
      end else begin
        gy <= gdiff_yx >> 1;
      end
    end
  end

  assign div_dividend = cmd.div_den ? mag_ad : mag_an;

  rau_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (g),
    .quotient (q_div),
    .busy     (div_busy),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.qn_load) qn <= q_div;
  end

  assign stat.op         = op_q;
  assign stat.a_num_zero = an_zero;
  assign stat.a_den_zero = ad_zero;
  assign stat.gcd_done   = gx == gy;
  assign stat.div_busy   = div_busy;
  assign stat.div_done   = div_done;

  assign sum  = p1 + p2;
  assign diff = p1 - p2;

  always_comb begin
    r_num = '0;
    r_den = '0;
    r_ct  = 1'b0;
    r_zd  = 1'b0;
    unique case (op_q)
      rau_pkg::CMD_ADD: begin
        r_num = rau_pkg::num_t'(sum);
        r_den = rau_pkg::den_t'(pd);
        r_zd  = ad_zero || bd_zero;
      end
      rau_pkg::CMD_SUB: begin
        r_num = rau_pkg::num_t'(diff);
        r_den = rau_pkg::den_t'(pd);
        r_zd  = ad_zero || bd_zero;
      end
      rau_pkg::CMD_MUL: begin
        r_num = rau_pkg::num_t'(p1);
        r_den = rau_pkg::den_t'(pd);
        r_zd  = ad_zero || bd_zero;
      end
      rau_pkg::CMD_DIV: begin
        r_num = rau_pkg::num_t'(p1);
        r_den = rau_pkg::den_t'(pd);
        r_zd  = ad_zero || bn_zero;
      end
      rau_pkg::CMD_GT: r_ct = p1 > p2;
      rau_pkg::CMD_LT: r_ct = p1 < p2;
      rau_pkg::CMD_EQ: r_ct = p1 == p2;
      rau_pkg::CMD_NE: r_ct = p1 != p2;
      rau_pkg::CMD_RED: begin
        priority if (ad_zero) begin
          r_num = rau_pkg::num_t'(an_q);
          r_den = rau_pkg::den_t'(ad_q);
          r_zd  = 1'b1;
        end else if (an_zero) begin
          r_num = '0;
          r_den = rau_pkg::den_t'(1);
        end else begin
          // sign of the fraction goes on the numerator
          r_num = (an_q[rau_pkg::OPW-1] ^ ad_q[rau_pkg::OPW-1])
                  ? -rau_pkg::num_t'(qn) : rau_pkg::num_t'(qn);
          r_den = rau_pkg::den_t'(q_div);
        end
      end
      rau_pkg::CMD_SWAP: begin
        r_num = rau_pkg::num_t'(ad_q);
        r_den = rau_pkg::den_t'(an_q);
        r_zd  = an_zero;
      end
      default: begin
        r_num = '0;
        r_den = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_num  <= r_num;
      res_den  <= r_den;
      cmp_true <= r_ct;
      zero_den <= r_zd;
    end
  end

endmodule

`default_nettype wire

>>> sv/rau_ctrl.sv
// controller state machine: sequences multiplies, gcd and divisions,
// owns the input and output handshakes; depends on rau_pkg and the defines
`default_nettype none

`include "rational_arithmetic_unit_defines.svh"

module rau_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire rau_pkg::dp_stat_t stat,
  output rau_pkg::dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_GCD,
    S_DIVN,
    S_WAITN,
    S_DIVD,
    S_WAITD,
    S_FIN
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = state == S_IDLE;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.mul_step = rau_pkg::MS_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        // codes up to ne all go through the cross products
        priority if (stat.op <= rau_pkg::CMD_NE) begin
          state_next = S_MUL1;
        end else if (stat.op == rau_pkg::CMD_RED && !stat.a_num_zero &&
                     !stat.a_den_zero) begin
          cmd.gcd_init = 1'b1;
          state_next   = S_GCD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_MUL1: begin
        cmd.mul_step = rau_pkg::MS_P1;
        state_next   = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_step = rau_pkg::MS_P2;
        state_next   = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul_step = rau_pkg::MS_PD;
        state_next   = S_FIN;
      end
      S_GCD: begin
        if (stat.gcd_done) begin
          state_next = S_DIVN;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIVN: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAITN;
      end
      S_WAITN: begin
        if (stat.div_done) begin
          cmd.qn_load = 1'b1;
          state_next  = S_DIVD;
        end
      end
      S_DIVD: begin
        cmd.div_start = 1'b1;
        cmd.div_den   = 1'b1;
        state_next    = S_WAITD;
      end
      S_WAITD: begin
        // denominator quotient stays in the divider until the next start
        cmd.div_den = 1'b1;
        if (stat.div_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `RAU_ASSERT_NEXT(a_accept_blocks, in_valid && in_ready, !in_ready, "accepted while busy")
  `RAU_ASSERT_IMPL(a_load_free, cmd.out_load, out_free, "result overwrote a pending word")
  `RAU_ASSERT_IMPL(a_div_idle, cmd.div_start, !stat.div_busy, "divider restarted while busy")
  `RAU_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid && in_ready, "result load not shown")

endmodule

`default_nettype wire

>>> sv/rational_arithmetic_unit.sv
// channel  direction  fields                                  handshake
// in       input      cmd, a_num, a_den, b_num, b_den          in_valid / in_ready
// out      output     res_num, res_den, cmp_true, zero_den     out_valid / out_ready
//
// one word in at a time; the result register frees the input while a word waits
// add, sub, mul, div and compares take three passes through the
// single 16x16 multiplier; swap and trivial reduce skip the multiplier
// full reduce: binary gcd, then two divisions in the shared divider,
// one for the numerator and one for the denominator
// reset is synchronous; a stalled out channel holds the finished word
`default_nettype none

module rational_arithmetic_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rau_pkg::code_t cmd,
  input  wire rau_pkg::opd_t  a_num,
  input  wire rau_pkg::opd_t  a_den,
  input  wire rau_pkg::opd_t  b_num,
  input  wire rau_pkg::opd_t  b_den,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rau_pkg::num_t       res_num,
  output rau_pkg::den_t       res_den,
  output logic                cmp_true,
  output logic                zero_den
);

  rau_pkg::dp_cmd_t  dp_cmd;
  rau_pkg::dp_stat_t dp_stat;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  rau_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .op_in    (cmd),
    .a_num    (a_num),
    .a_den    (a_den),
    .b_num    (b_num),
    .b_den    (b_den),
    .res_num  (res_num),
    .res_den  (res_den),
    .cmp_true (cmp_true),
    .zero_den (zero_den)
  );

endmodule

`default_nettype wire
